[hdl/frb_pkg.sv]
// shared types and constants of the flow record batcher
`default_nettype none
package frb_pkg;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int REG_SEL_W  = 2;

	localparam logic [REG_SEL_W-1:0] REG_NET_MASK     = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_NET_BASE     = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_MIN_INTERVAL = 2'd2;

	localparam logic [31:0] NET_MASK_RESET     = 32'hFFFF_0000;
	localparam logic [31:0] NET_BASE_RESET     = 32'h0000_0000;
	localparam logic [15:0] MIN_INTERVAL_RESET = 16'd41;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] packet_length;
		logic [1:0]  packet_kind;
		logic [31:0] now_ms;
	} frb_pkt_t;

	typedef struct packed {
		logic        incoming;
		logic [31:0] host_bits;
		logic [1:0]  record_kind;
		logic [15:0] record_length;
	} frb_rec_t;

	typedef struct packed {
		frb_rec_t rec;
		logic     last_of_batch;
	} frb_out_t;

	typedef struct packed {
		logic [31:0] net_mask;
		logic [31:0] net_base;
		logic [15:0] min_interval_ms;
	} frb_cfg_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic flush_begin;
		logic rd_issue;
		logic out_load;
	} frb_cmd_t;

	typedef struct packed {
		logic flush_go;
		logic out_free;
		logic rd_last;
	} frb_sts_t;

endpackage
`default_nettype wire

[hdl/frb_ifs.sv]
// request channel interfaces for packet summaries and flow records
`default_nettype none
interface frb_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] packet_length;
	logic [1:0]  packet_kind;
	logic [31:0] now_ms;

	modport source (
		output valid, source_address, dest_address, packet_length, packet_kind, now_ms,
		input  ready
	);
	modport sink (
		input  valid, source_address, dest_address, packet_length, packet_kind, now_ms,
		output ready
	);
endinterface

interface frb_rec_if;
	logic        valid;
	logic        ready;
	logic        incoming;
	logic [31:0] host_bits;
	logic [1:0]  record_kind;
	logic [15:0] record_length;
	logic        last_of_batch;

	modport source (
		output valid, incoming, host_bits, record_kind, record_length, last_of_batch,
		input  ready
	);
	modport sink (
		input  valid, incoming, host_bits, record_kind, record_length, last_of_batch,
		output ready
	);
endinterface
`default_nettype wire

[hdl/frb_ctrl.sv]
// controller state machine of the flow record batcher
`default_nettype none
module frb_ctrl
	import frb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pkt_valid,
	output logic          pkt_ready,
	input  wire frb_sts_t sts,
	output frb_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_EVAL    = 4'b0010,
		ST_RD      = 4'b0100,
		ST_LOAD    = 4'b1000
	} frb_state_t;

	frb_state_t state_q;
	frb_state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		pkt_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pkt_ready = 1'b1;
				if (pkt_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.commit = 1'b1;
				if (sts.flush_go) begin
					cmd.flush_begin = 1'b1;
					state_d         = ST_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				if (sts.out_free) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = sts.rd_last ? ST_IDLE : ST_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/frb_dp.sv]
// datapath: classification, record memory, flush timer and output register
`default_nettype none
module frb_dp
	import frb_pkg::*;
#(
	parameter int BATCH_DEPTH = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire frb_cfg_t cfg,
	input  wire frb_pkt_t pkt,
	input  wire frb_cmd_t cmd,
	output frb_sts_t      sts,
	output logic          out_valid,
	output frb_out_t      out_data,
	input  wire logic     out_ready
);

	localparam int AW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
	localparam int CW = $clog2(BATCH_DEPTH + 1);

	frb_pkt_t    item_q;
	frb_rec_t    mem_q [BATCH_DEPTH];
	frb_rec_t    rd_data_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] flush_n_q;
	logic [CW-1:0] rd_idx_q;
	logic        last_rd_q;
	logic [31:0] last_flush_q;
	logic        out_valid_q;
	frb_out_t    out_q;

	logic        src_local;
	logic        dst_local;
	logic        match;
	logic        full;
	logic        late;
	logic [32:0] deadline;
	frb_rec_t    rec;
	logic        out_fire;

	assign src_local = (item_q.source_address & cfg.net_mask) == cfg.net_base;
	assign dst_local = (item_q.dest_address & cfg.net_mask) == cfg.net_base;
	assign match     = src_local || dst_local;

	always_comb begin
		rec.incoming      = !src_local;
		rec.host_bits     = (src_local ? item_q.source_address : item_q.dest_address)
			& ~cfg.net_mask;
		rec.record_kind   = item_q.packet_kind;
		rec.record_length = item_q.packet_length;
	end

	assign deadline = {1'b0, last_flush_q} + {17'b0, cfg.min_interval_ms};
	assign late     = deadline < {1'b0, item_q.now_ms};
	assign full     = count_q == CW'(BATCH_DEPTH - 1);

	assign out_fire     = out_valid_q && out_ready;
	assign sts.flush_go = match && (full || late);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.rd_last  = last_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= pkt;
		end
		if (cmd.commit && match) begin
			mem_q[count_q[AW-1:0]] <= rec;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
		end
		if (cmd.out_load) begin
			out_q.rec           <= rd_data_q;
			out_q.last_of_batch <= last_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			flush_n_q    <= '0;
			rd_idx_q     <= '0;
			last_rd_q    <= 1'b0;
			last_flush_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit && match) begin
				if (cmd.flush_begin) begin
					count_q      <= '0;
					flush_n_q    <= count_q + CW'(1);
					rd_idx_q     <= '0;
					last_flush_q <= item_q.now_ms;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.rd_issue) begin
				rd_idx_q  <= rd_idx_q + CW'(1);
				last_rd_q <= (rd_idx_q + CW'(1)) == flush_n_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

[hdl/flow_record_batcher.sv]
// flow record batcher top level with configuration registers
// Each packet summary is first captured and then classified against the monitored
// network; its record is stored if it matches and the flush conditions are tested.
// A flush sends the buffered records oldest first, each record going through the single
// read port of the record memory and then the output register; during a flush no summary
// is taken. A flush holds the input until its last record is loaded into the output
// register, where that record may still wait while the next summary is taken.
// Registers: net_mask at 0x0, net_base at 0x4, min_interval_ms at 0x8. No clearing pass
// is needed after reset.
`default_nettype none
module flow_record_batcher
	import frb_pkg::*;
#(
	parameter int BATCH_DEPTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	frb_pkt_if.sink                    pkt,
	frb_rec_if.source                  rec,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	frb_cfg_t cfg_q;
	frb_cmd_t cmd;
	frb_sts_t sts;
	frb_pkt_t pkt_data;
	frb_out_t out_data;
	logic     out_valid;
	logic     cfg_wr;
	logic [REG_SEL_W-1:0] reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.net_mask        <= NET_MASK_RESET;
			cfg_q.net_base        <= NET_BASE_RESET;
			cfg_q.min_interval_ms <= MIN_INTERVAL_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_NET_MASK:     cfg_q.net_mask        <= pwdata;
				REG_NET_BASE:     cfg_q.net_base        <= pwdata;
				REG_MIN_INTERVAL: cfg_q.min_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_NET_MASK:     prdata = cfg_q.net_mask;
			REG_NET_BASE:     prdata = cfg_q.net_base;
			REG_MIN_INTERVAL: prdata = {16'b0, cfg_q.min_interval_ms};
			default:          prdata = '0;
		endcase
	end

	assign pkt_data.source_address = pkt.source_address;
	assign pkt_data.dest_address   = pkt.dest_address;
	assign pkt_data.packet_length  = pkt.packet_length;
	assign pkt_data.packet_kind    = pkt.packet_kind;
	assign pkt_data.now_ms         = pkt.now_ms;

	frb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	frb_dp #(
		.BATCH_DEPTH (BATCH_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pkt       (pkt_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (rec.ready)
	);

	assign rec.valid         = out_valid;
	assign rec.incoming      = out_data.rec.incoming;
	assign rec.host_bits     = out_data.rec.host_bits;
	assign rec.record_kind   = out_data.rec.record_kind;
	assign rec.record_length = out_data.rec.record_length;
	assign rec.last_of_batch = out_data.last_of_batch;

endmodule
`default_nettype wire

[verif/flow_record_batcher_test.sv]
// testbench of the flow record batcher: directed and random packet summaries, flushed records checked in order
`timescale 1ns / 100ps
module flow_record_batcher_test;
	import frb_pkg::*;

	localparam int BATCH_DEPTH    = 32;
	localparam int RANDOM_PER_RUN = 70;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	frb_pkt_if pkt_bus ();
	frb_rec_if rec_bus ();

	flow_record_batcher #(
		.BATCH_DEPTH(BATCH_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt_bus),
		.rec     (rec_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	frb_cfg_t    model_cfg = '{NET_MASK_RESET, NET_BASE_RESET, MIN_INTERVAL_RESET};
	frb_rec_t    batch_store [BATCH_DEPTH];
	int          batch_fill = 0;
	logic [31:0] last_flush_ms = '0;
	logic [31:0] clock_ms = '0;

	frb_pkt_t pending_pkts [$];
	frb_out_t expected_records [$];
	frb_pkt_t offered_pkt;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int stall_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	// classify one accepted summary and queue the records of any flush it causes
	task automatic absorb_packet(input frb_pkt_t p);
		frb_rec_t    r;
		frb_out_t    o;
		logic [32:0] deadline;
		if ((p.source_address & model_cfg.net_mask) == model_cfg.net_base) begin
			r.incoming  = 1'b0;
			r.host_bits = p.source_address & ~model_cfg.net_mask;
		end else if ((p.dest_address & model_cfg.net_mask) == model_cfg.net_base) begin
			r.incoming  = 1'b1;
			r.host_bits = p.dest_address & ~model_cfg.net_mask;
		end else begin
			return;
		end
		r.record_kind   = p.packet_kind;
		r.record_length = p.packet_length;
		batch_store[batch_fill] = r;
		batch_fill++;
		deadline = {1'b0, last_flush_ms} + {17'b0, model_cfg.min_interval_ms};
		if (batch_fill == BATCH_DEPTH || deadline < {1'b0, p.now_ms}) begin
			for (int i = 0; i < batch_fill; i++) begin
				o.rec           = batch_store[i];
				o.last_of_batch = (i == batch_fill - 1);
				expected_records.push_back(o);
			end
			batch_fill    = 0;
			last_flush_ms = p.now_ms;
		end
	endtask

	task automatic check_record();
		frb_out_t got;
		frb_out_t want;
		got.rec.incoming      = rec_bus.incoming;
		got.rec.host_bits     = rec_bus.host_bits;
		got.rec.record_kind   = rec_bus.record_kind;
		got.rec.record_length = rec_bus.record_length;
		got.last_of_batch     = rec_bus.last_of_batch;
		if (expected_records.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected record: incoming %0b host %h kind %0d length %0d last %0b",
					got.rec.incoming, got.rec.host_bits, got.rec.record_kind,
					got.rec.record_length, got.last_of_batch);
			return;
		end
		want = expected_records.pop_front();
		if (got.rec.incoming !== want.rec.incoming || got.rec.host_bits !== want.rec.host_bits ||
				got.rec.record_kind !== want.rec.record_kind ||
				got.rec.record_length !== want.rec.record_length ||
				got.last_of_batch !== want.last_of_batch) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("record mismatch: expected %0b %h %0d %0d %0b, got %0b %h %0d %0d %0b",
					want.rec.incoming, want.rec.host_bits, want.rec.record_kind,
					want.rec.record_length, want.last_of_batch,
					got.rec.incoming, got.rec.host_bits, got.rec.record_kind,
					got.rec.record_length, got.last_of_batch);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_bus.valid          <= 1'b0;
			pkt_bus.source_address <= '0;
			pkt_bus.dest_address   <= '0;
			pkt_bus.packet_length  <= '0;
			pkt_bus.packet_kind    <= '0;
			pkt_bus.now_ms         <= '0;
		end else if (!pkt_bus.valid || pkt_bus.ready) begin
			if (pkt_bus.valid)
				absorb_packet(offered_pkt);
			if (pending_pkts.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				offered_pkt = pending_pkts.pop_front();
				pkt_bus.valid          <= 1'b1;
				pkt_bus.source_address <= offered_pkt.source_address;
				pkt_bus.dest_address   <= offered_pkt.dest_address;
				pkt_bus.packet_length  <= offered_pkt.packet_length;
				pkt_bus.packet_kind    <= offered_pkt.packet_kind;
				pkt_bus.now_ms         <= offered_pkt.now_ms;
			end else begin
				pkt_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_bus.ready <= 1'b0;
		end else begin
			if (rec_bus.valid && rec_bus.ready)
				check_record();
			if (holds_served != hold_requests) begin
				stall_left = LONG_HOLD;
				holds_served++;
			end
			if (stall_left > 0) begin
				stall_left--;
				rec_bus.ready <= 1'b0;
			end else begin
				rec_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pkt_bus.valid && pkt_bus.ready) || (rec_bus.valid && rec_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input logic [REG_SEL_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_NET_MASK:     model_cfg.net_mask = value;
			REG_NET_BASE:     model_cfg.net_base = value;
			REG_MIN_INTERVAL: model_cfg.min_interval_ms = value[15:0];
			default:          ;
		endcase
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pending_pkts.size() != 0 || pkt_bus.valid || expected_records.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic frb_pkt_t pkt_of(input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] len, input logic [1:0] kind, input logic [31:0] now);
		frb_pkt_t p;
		p.source_address = src;
		p.dest_address   = dst;
		p.packet_length  = len;
		p.packet_kind    = kind;
		p.now_ms         = now;
		return p;
	endfunction

	function automatic frb_pkt_t random_packet();
		frb_pkt_t    p;
		logic [31:0] net_a;
		logic [31:0] net_b;
		logic [31:0] far_a;
		logic [31:0] far_b;
		int          pick;
		net_a = (model_cfg.net_base & model_cfg.net_mask) | ($urandom() & ~model_cfg.net_mask);
		net_b = (model_cfg.net_base & model_cfg.net_mask) | ($urandom() & ~model_cfg.net_mask);
		far_a = $urandom();
		far_b = $urandom();
		pick = $urandom_range(99);
		if (pick < 45) begin
			p.source_address = net_a;
			p.dest_address   = far_b;
		end else if (pick < 80) begin
			p.source_address = far_a;
			p.dest_address   = net_b;
		end else if (pick < 90) begin
			p.source_address = net_a;
			p.dest_address   = net_b;
		end else begin
			p.source_address = far_a;
			p.dest_address   = far_b;
		end
		p.packet_length = 16'($urandom());
		p.packet_kind   = 2'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 4) begin
			p.now_ms = clock_ms - 32'($urandom_range(100, 1));
		end else begin
			if (pick < 6)
				clock_ms = $urandom();
			else
				clock_ms += 32'($urandom_range(3));
			p.now_ms = clock_ms;
		end
		return p;
	endfunction

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: first matching packet, timer edge, time running backwards
		pending_pkts.push_back(pkt_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 32'hFFFF_FFFF));
		pending_pkts.push_back(pkt_of(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 2'd0, 32'd42));
		pending_pkts.push_back(pkt_of(32'h0001_0000, 32'h0000_FFFF, 16'hFFFF, 2'd1, 32'd5));
		pending_pkts.push_back(pkt_of(32'h0000_ABCD, 32'h0000_1111, 16'h8000, 2'd2, 32'd83));
		pending_pkts.push_back(pkt_of(32'hFFFF_0000, 32'h0000_1234, 16'h0001, 2'd3, 32'd84));
		pending_pkts.push_back(pkt_of(32'h0000_7777, 32'hDEAD_BEEF, 16'h00FF, 2'd0, 32'd0));
		settle();

		apb_write(REG_NET_MASK, 32'hFFFF_FFFF);
		apb_write(REG_NET_BASE, 32'hC0A8_0001);
		apb_write(REG_MIN_INTERVAL, 32'd0);
		@(negedge clk);
		pending_pkts.push_back(pkt_of(32'hC0A8_0001, 32'h0000_0000, 16'h1234, 2'd1, 32'd84));
		pending_pkts.push_back(pkt_of(32'h0000_0000, 32'hC0A8_0001, 16'h4321, 2'd2, 32'd85));
		pending_pkts.push_back(pkt_of(32'h7FFF_FFFF, 32'h0000_0000, 16'h7FFF, 2'd1, 32'd900));
		settle();

		apb_write(REG_NET_MASK, 32'h0000_0000);
		apb_write(REG_NET_BASE, 32'h0000_0000);
		apb_write(REG_MIN_INTERVAL, 32'd65535);
		@(negedge clk);
		pending_pkts.push_back(pkt_of(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 2'd3, 32'hFFFF_FFFF));
		pending_pkts.push_back(pkt_of(32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'h5A5A, 2'd1, 32'hFFFF_FFFF));
		pending_pkts.push_back(pkt_of(32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hA5A5, 2'd2, 32'h0000_0000));
		settle();

		// base outside a zero mask: nothing can match
		apb_write(REG_NET_BASE, 32'h0000_0001);
		@(negedge clk);
		pending_pkts.push_back(pkt_of(32'h0000_0001, 32'h0000_0001, 16'h0001, 2'd0, 32'hFFFF_FFFF));
		settle();

		for (int run = 0; run < 4; run++) begin
			logic [31:0] mask;
			logic [15:0] interval;
			case (run)
				0: begin mask = 32'hFFFF_FF00; interval = 16'd20;    end
				1: begin mask = 32'hFFFF_0000; interval = 16'd41;    end
				2: begin mask = 32'hFFFF_FFFF << $urandom_range(31, 1); interval = 16'd65535; end
				default: begin mask = 32'hFFFF_FFF0; interval = 16'd0; end
			endcase
			apb_write(REG_NET_MASK, mask);
			apb_write(REG_NET_BASE, $urandom() & mask);
			apb_write(REG_MIN_INTERVAL, {16'b0, interval});
			@(negedge clk);
			src_idle_pct   = (run == 1) ? 80 : (run == 3) ? 6 : 0;
			sink_stall_pct = (run == 2) ? 80 : (run == 3) ? 6 : 0;
			if (run != 0)
				clock_ms = $urandom();
			for (int n = 0; n < RANDOM_PER_RUN; n++)
				pending_pkts.push_back(random_packet());
			if (run == 0) begin
				repeat (20) @(negedge clk);
				hold_requests++;
			end
			settle();
		end

		if (mismatch_count == 0 && expected_records.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/frb_pkg.sv
hdl/frb_ifs.sv
hdl/frb_ctrl.sv
hdl/frb_dp.sv
hdl/flow_record_batcher.sv
verif/flow_record_batcher_test.sv
